@@ hdl/hse_pkg.sv @@
// Package for the Huffman symbol encoder: entry and command types, the
// sequencer state type and the character-to-symbol mapping.
// Used by all modules of the block; depends on nothing.
package hse_pkg;

  localparam int CODE_W = 64;
  localparam int SIZE_W = 7;
  localparam int BYTE_W = 8;
  localparam int SYM_W  = 7;

  localparam logic [SYM_W-1:0] SYM_UPPER_BASE = 7'd26;
  localparam logic [SYM_W-1:0] SYM_DIGIT_BASE = 7'd52;
  localparam logic [SYM_W-1:0] SYM_UNDERSCORE = 7'd62;
  localparam logic [SYM_W-1:0] SYM_LBRACE     = 7'd63;
  localparam logic [SYM_W-1:0] SYM_RBRACE     = 7'd64;

  typedef enum logic [1:0] {
    ACT_WRITE  = 2'd0,
    ACT_ENCODE = 2'd1,
    ACT_FLUSH  = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_SHIFT
  } state_e;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic [SIZE_W-1:0] size;
  } entry_t;

  // Commands handed to the sequencer when a request is accepted.
  typedef struct packed {
    logic encode;
    logic flush;
  } cmd_t;

  typedef struct packed {
    logic             hit;
    logic [SYM_W-1:0] sym;
  } sym_t;

  function automatic sym_t char_to_symbol(input logic [7:0] c);
    sym_t r;
    logic [7:0] off;
    r   = '0;
    off = '0;
    if (c >= 8'h61 && c <= 8'h7a) begin
      off   = c - 8'h61;
      r.hit = 1'b1;
      r.sym = off[SYM_W-1:0];
    end else if (c >= 8'h41 && c <= 8'h5a) begin
      off   = c - 8'h41;
      r.hit = 1'b1;
      r.sym = off[SYM_W-1:0] + SYM_UPPER_BASE;
    end else if (c >= 8'h30 && c <= 8'h39) begin
      off   = c - 8'h30;
      r.hit = 1'b1;
      r.sym = off[SYM_W-1:0] + SYM_DIGIT_BASE;
    end else if (c == 8'h5f) begin
      r.hit = 1'b1;
      r.sym = SYM_UNDERSCORE;
    end else if (c == 8'h7b) begin
      r.hit = 1'b1;
      r.sym = SYM_LBRACE;
    end else if (c == 8'h7d) begin
      r.hit = 1'b1;
      r.sym = SYM_RBRACE;
    end
    return r;
  endfunction

endpackage

@@ hdl/hse_table.sv @@
// Code table memory: one write port, one registered read port.
// Per-entry valid bits make unwritten entries read as zero after reset.
// Depends on hse_pkg.
module hse_table
  import hse_pkg::*;
#(
  parameter int DEPTH  = 65,
  parameter int ADDR_W = 7
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              wr_en_i,
  input  logic [ADDR_W-1:0] wr_addr_i,
  input  entry_t            wr_data_i,
  input  logic              rd_en_i,
  input  logic [ADDR_W-1:0] rd_addr_i,
  output entry_t            rd_data_o
);

  entry_t mem_q [DEPTH];
  logic   valid_q [DEPTH];
  entry_t rd_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DEPTH; i++) begin
        valid_q[i] <= 1'b0;
      end
    end else if (wr_en_i) begin
      valid_q[wr_addr_i] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= valid_q[rd_addr_i] ? mem_q[rd_addr_i] : '0;
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

@@ hdl/hse_ctrl.sv @@
// Sequencer and shared shift unit of the bit packer, with the output register.
// Moves up to one byte of code bits into the accumulator per unstalled cycle.
// Depends on hse_pkg.
module hse_ctrl
  import hse_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cmd_t              cmd_i,
  input  entry_t            entry_i,
  output logic              busy_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [BYTE_W-1:0] out_byte_o,
  output logic              last_of_run_o
);

  state_e            state_q, state_d;
  logic [SIZE_W-1:0] rem_q, rem_d;
  logic [6:0]        acc_q, acc_d;
  logic [2:0]        cnt_q, cnt_d;
  logic              out_valid_q, out_valid_d;
  logic [BYTE_W-1:0] out_byte_q, out_byte_d;
  logic              last_q, last_d;

  logic              out_free;
  logic [3:0]        space;
  logic [3:0]        take;
  logic [SIZE_W-1:0] shamt;
  logic [CODE_W-1:0] shifted;
  logic [8:0]        mask_w;
  logic [BYTE_W-1:0] chunk;
  logic [15:0]       acc_w;
  logic [BYTE_W-1:0] new_acc;
  logic [3:0]        new_cnt;
  logic [SIZE_W-1:0] rem_next;
  logic [15:0]       flush_w;

  assign out_free = !out_valid_q || !out_stall_i;

  // Shared shift unit: take as many leading code bits as fit in the
  // partial byte and append them below the pending bits.
  always_comb begin
    space    = 4'd8 - {1'b0, cnt_q};
    take     = (rem_q < {3'b000, space}) ? rem_q[3:0] : space;
    shamt    = rem_q - {3'b000, take};
    shifted  = entry_i.code >> shamt;
    mask_w   = (9'd1 << take) - 9'd1;
    chunk    = shifted[BYTE_W-1:0] & mask_w[BYTE_W-1:0];
    acc_w    = {9'b0, acc_q} << take;
    new_acc  = acc_w[BYTE_W-1:0] | chunk;
    new_cnt  = {1'b0, cnt_q} + take;
    rem_next = shamt;
    flush_w  = {9'b0, acc_q} << space;
  end

  always_comb begin
    state_d     = state_q;
    rem_d       = rem_q;
    acc_d       = acc_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_byte_d  = out_byte_q;
    last_d      = last_q;

    unique case (state_q)
      ST_IDLE: begin
        if (cmd_i.encode) begin
          state_d = ST_LOAD;
        end else if (cmd_i.flush && cnt_q != 3'd0) begin
          // The top level only accepts a flush when the output slot is free.
          out_valid_d = 1'b1;
          out_byte_d  = flush_w[BYTE_W-1:0];
          last_d      = 1'b1;
          acc_d       = '0;
          cnt_d       = '0;
        end
      end
      ST_LOAD: begin
        rem_d   = entry_i.size;
        state_d = (entry_i.size == '0) ? ST_IDLE : ST_SHIFT;
      end
      ST_SHIFT: begin
        if (out_free) begin
          rem_d = rem_next;
          if (new_cnt == 4'd8) begin
            out_valid_d = 1'b1;
            out_byte_d  = new_acc;
            // No further byte follows unless a full byte of code remains.
            last_d      = rem_next < SIZE_W'(BYTE_W);
            acc_d       = '0;
            cnt_d       = '0;
          end else begin
            acc_d = new_acc[6:0];
            cnt_d = new_cnt[2:0];
          end
          if (rem_next == '0) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      rem_q       <= '0;
      acc_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rem_q       <= rem_d;
      acc_q       <= acc_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_byte_q <= out_byte_d;
    last_q     <= last_d;
  end

  assign busy_o        = state_q != ST_IDLE;
  assign out_valid_o   = out_valid_q;
  assign out_byte_o    = out_byte_q;
  assign last_of_run_o = last_q;

endmodule

@@ hdl/huffman_symbol_encoder_core.sv @@
// Huffman symbol encoder with a writable code table. An encode request
// reads and loads its table entry, then emits each full byte of code bits
// and leaves trailing bits pending; the shift unit moves at most one byte
// of code bits per cycle while the output is not stalled. A flush emits the pending bits zero-padded.
// Reset is asynchronous; per-entry valid bits clear the table at once.
module huffman_symbol_encoder_core
  import hse_pkg::*;
#(
  parameter int ALPHABET_SIZE = 65,
  parameter int MAX_CODE_LEN  = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [1:0]        action_i,
  input  logic [7:0]        symbol_char_i,
  input  logic [6:0]        table_index_i,
  input  logic [CODE_W-1:0] code_word_i,
  input  logic [SIZE_W-1:0] code_size_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [BYTE_W-1:0] out_byte_o,
  output logic              last_of_run_o
);

  localparam int ADDR_W = (ALPHABET_SIZE > 1) ? $clog2(ALPHABET_SIZE) : 1;

  logic              accept;
  logic              busy;
  sym_t              sym;
  logic              sym_ok;
  logic              idx_ok;
  logic              wr_en;
  logic              rd_en;
  entry_t            wr_data;
  entry_t            rd_data;
  cmd_t              cmd;

  assign in_stall_o = busy || (out_valid_o && out_stall_i);
  assign accept     = in_valid_i && !in_stall_o;

  assign sym    = char_to_symbol(symbol_char_i);
  assign sym_ok = sym.hit && (int'(sym.sym) < ALPHABET_SIZE);
  assign idx_ok = int'(table_index_i) < ALPHABET_SIZE;

  always_comb begin
    wr_en        = 1'b0;
    cmd          = '0;
    wr_data.code = code_word_i;
    wr_data.size = (int'(code_size_i) > MAX_CODE_LEN) ? SIZE_W'(MAX_CODE_LEN) : code_size_i;
    case (action_i)
      ACT_WRITE:  wr_en      = accept && idx_ok;
      ACT_ENCODE: cmd.encode = accept && sym_ok;
      ACT_FLUSH:  cmd.flush  = accept;
      default: ;
    endcase
  end

  assign rd_en = cmd.encode;

  hse_table #(
    .DEPTH  (ALPHABET_SIZE),
    .ADDR_W (ADDR_W)
  ) u_table (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (wr_en),
    .wr_addr_i (ADDR_W'(table_index_i)),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (ADDR_W'(sym.sym)),
    .rd_data_o (rd_data)
  );

  hse_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .entry_i       (rd_data),
    .busy_o        (busy),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_byte_o    (out_byte_o),
    .last_of_run_o (last_of_run_o)
  );

endmodule

@@ hdl/hse_checker.sv @@
// Port-level checks for the Huffman symbol encoder, bound to the top level.
// Depends on hse_pkg and huffman_symbol_encoder_core.
module hse_checker
  import hse_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input logic [1:0]        action_i,
  input logic [7:0]        symbol_char_i,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input logic [BYTE_W-1:0] out_byte_o,
  input logic              last_of_run_o
);

  logic in_acc;
  assign in_acc = in_valid_i && !in_stall_o;

  // A stalled result request holds its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_byte_o)
      && $stable(last_of_run_o))
    else $error("stalled output changed");

  // A table write never produces a byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && action_i == ACT_WRITE && !out_valid_o |=> !out_valid_o)
    else $error("table write produced output");

  // Encoding the mapped character a (8'h61) keeps the block busy for the table read.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && action_i == ACT_ENCODE && symbol_char_i == 8'h61 |=> in_stall_o)
    else $error("encode request did not start the sequencer");

  // While a byte that is not the last of its run is shown, no new request
  // may be taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_of_run_o |-> in_stall_o)
    else $error("request accepted in the middle of a run");

endmodule

bind huffman_symbol_encoder_core hse_checker u_hse_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .action_i      (action_i),
  .symbol_char_i (symbol_char_i),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .out_byte_o    (out_byte_o),
  .last_of_run_o (last_of_run_o)
);
